// File: design/frf_pkg.sv
package frf_pkg;

  localparam int unsigned LANES    = 8;
  localparam int unsigned NUM_EXCL = 3;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned SIZE_W   = 32;

  typedef enum logic [CFG_AW-1:0] {
    CFG_MIN_LCN     = 3'd0,
    CFG_MIN_SIZE    = 3'd1,
    CFG_EXCL0_START = 3'd2,
    CFG_EXCL0_END   = 3'd3,
    CFG_EXCL1_START = 3'd4,
    CFG_EXCL1_END   = 3'd5,
    CFG_EXCL2_START = 3'd6,
    CFG_EXCL2_END   = 3'd7
  } cfg_reg_e;

endpackage

// File: design/frf_lane.sv
module frf_lane #(
  parameter int unsigned LCN_WIDTH = 40,
  parameter int unsigned LANE_IDX  = 0
) (
  input  logic [LCN_WIDTH-1:0] base_lcn_i,
  input  logic                 bit_i,
  input  logic [LCN_WIDTH-1:0] excl_lo_i [frf_pkg::NUM_EXCL],
  input  logic [LCN_WIDTH-1:0] excl_hi_i [frf_pkg::NUM_EXCL],
  output logic [LCN_WIDTH-1:0] lcn_o,
  output logic                 used_o
);
  import frf_pkg::*;

  logic [NUM_EXCL-1:0] in_range;

  assign lcn_o = base_lcn_i + LCN_WIDTH'(LANE_IDX);

  always_comb begin
    for (int k = 0; k < NUM_EXCL; k++) begin
      in_range[k] = (lcn_o >= excl_lo_i[k]) && (lcn_o < excl_hi_i[k]);
    end
  end

  assign used_o = bit_i | (|in_range);

endmodule

// File: design/frf_merge.sv
module frf_merge #(
  parameter int unsigned LCN_WIDTH = 40
) (
  input  logic [LCN_WIDTH-1:0]        lcn_i [frf_pkg::LANES],
  input  logic [frf_pkg::LANES-1:0]   used_i,
  input  logic [LCN_WIDTH-1:0]        end_lcn_i,
  input  logic                        prev_used_i,
  input  logic [LCN_WIDTH-1:0]        run_start_i,
  input  logic [LCN_WIDTH-1:0]        min_lcn_i,
  input  logic [frf_pkg::SIZE_W-1:0]  min_size_i,
  output logic                        hit_o,
  output logic [LCN_WIDTH-1:0]        hit_begin_o,
  output logic [LCN_WIDTH-1:0]        hit_end_o,
  output logic                        tail_ok_o,
  output logic                        next_prev_used_o,
  output logic [LCN_WIDTH-1:0]        next_run_start_o
);
  import frf_pkg::*;

  logic [LCN_WIDTH-1:0] min_size_ext;
  logic [LCN_WIDTH-1:0] tail_len;

  assign min_size_ext = LCN_WIDTH'(min_size_i);

  // Lanes are walked in cluster order; the first run that closes and
  // qualifies wins.
  always_comb begin
    logic                 pu;
    logic [LCN_WIDTH-1:0] rs;
    logic [LCN_WIDTH-1:0] len;
    pu          = prev_used_i;
    rs          = run_start_i;
    hit_o       = 1'b0;
    hit_begin_o = '0;
    hit_end_o   = '0;
    for (int k = 0; k < LANES; k++) begin
      len = lcn_i[k] - rs;
      if (!hit_o && !pu && used_i[k] && (rs >= min_lcn_i) && (len >= min_size_ext)) begin
        hit_o       = 1'b1;
        hit_begin_o = rs;
        hit_end_o   = lcn_i[k];
      end
      if (pu && !used_i[k]) begin
        rs = lcn_i[k];
      end
      pu = used_i[k];
    end
    next_prev_used_o = pu;
    next_run_start_o = rs;
  end

  assign tail_len  = end_lcn_i - next_run_start_o;
  assign tail_ok_o = !next_prev_used_o && (next_run_start_o >= min_lcn_i) &&
                     (tail_len >= min_size_ext);

endmodule

// File: design/free_cluster_run_finder.sv
// Channel | Direction | Beat contents
// s_axis  | in        | tdata: bitmap_byte, byte_lcn; tuser: scan_start; tlast: last_byte
// m_axis  | out       | tdata: run_begin, run_end; tuser: found
// cfg     | in        | cfg_addr_i: register index; cfg_data_i: value
//
// One bitmap byte is taken every cycle; eight lanes check its clusters in parallel.
// The result appears in the cycle after the byte that causes it, from an output register.
// The input stalls only while that register is full and m_axis_tready is low.
// Reset clears the scan state and loads the register defaults; configuration is
// always ready.
module free_cluster_run_finder #(
  parameter int unsigned LCN_WIDTH = 40
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [7:0] bitmap_byte, [LCN_WIDTH+7:8] byte_lcn
  input  logic [((8+LCN_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  // [0] scan_start
  input  logic                                    s_axis_tuser,
  input  logic                                    s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // [LCN_WIDTH-1:0] run_begin, [2*LCN_WIDTH-1:LCN_WIDTH] run_end
  output logic [((2*LCN_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  // [0] found
  output logic                                    m_axis_tuser,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [frf_pkg::CFG_AW-1:0]              cfg_addr_i,
  input  logic [LCN_WIDTH-1:0]                    cfg_data_i
);
  import frf_pkg::*;

  localparam int unsigned OUT_W = ((2*LCN_WIDTH+7)/8)*8;

  logic [LCN_WIDTH-1:0] min_lcn_q;
  logic [SIZE_W-1:0]    min_size_q;
  logic [LCN_WIDTH-1:0] excl_lo_q [NUM_EXCL];
  logic [LCN_WIDTH-1:0] excl_hi_q [NUM_EXCL];

  logic [LCN_WIDTH-1:0] counter_q;
  logic                 prev_used_q;
  logic [LCN_WIDTH-1:0] run_start_q;
  logic                 finished_q;

  logic                 out_valid_q;
  logic                 found_q;
  logic [LCN_WIDTH-1:0] run_begin_q;
  logic [LCN_WIDTH-1:0] run_end_q;

  logic [7:0]           bitmap_byte;
  logic [LCN_WIDTH-1:0] byte_lcn;
  logic                 scan_start;
  logic                 last_byte;

  logic                 in_beat;
  logic                 active;
  logic                 emit;
  logic [LCN_WIDTH-1:0] base_lcn;
  logic [LCN_WIDTH-1:0] end_lcn;
  logic                 eff_prev_used;
  logic [LCN_WIDTH-1:0] eff_run_start;

  logic [LCN_WIDTH-1:0] lane_lcn [LANES];
  logic [LANES-1:0]     lane_used;

  logic                 hit;
  logic [LCN_WIDTH-1:0] hit_begin;
  logic [LCN_WIDTH-1:0] hit_end;
  logic                 tail_ok;
  logic                 next_prev_used;
  logic [LCN_WIDTH-1:0] next_run_start;

  assign bitmap_byte = s_axis_tdata[7:0];
  assign byte_lcn    = s_axis_tdata[LCN_WIDTH+7:8];
  assign scan_start  = s_axis_tuser;
  assign last_byte   = s_axis_tlast;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lcn_q  <= '0;
      min_size_q <= SIZE_W'(1);
      for (int k = 0; k < NUM_EXCL; k++) begin
        excl_lo_q[k] <= '0;
        excl_hi_q[k] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_MIN_LCN:     min_lcn_q    <= cfg_data_i;
        CFG_MIN_SIZE:    min_size_q   <= cfg_data_i[SIZE_W-1:0];
        CFG_EXCL0_START: excl_lo_q[0] <= cfg_data_i;
        CFG_EXCL0_END:   excl_hi_q[0] <= cfg_data_i;
        CFG_EXCL1_START: excl_lo_q[1] <= cfg_data_i;
        CFG_EXCL1_END:   excl_hi_q[1] <= cfg_data_i;
        CFG_EXCL2_START: excl_lo_q[2] <= cfg_data_i;
        CFG_EXCL2_END:   excl_hi_q[2] <= cfg_data_i;
      endcase
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign active        = scan_start || !finished_q;
  assign emit          = in_beat && active && (hit || last_byte);

  assign base_lcn      = scan_start ? byte_lcn : counter_q;
  assign end_lcn       = base_lcn + LCN_WIDTH'(LANES);
  assign eff_prev_used = scan_start ? 1'b1 : prev_used_q;
  assign eff_run_start = scan_start ? '0 : run_start_q;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    frf_lane #(
      .LCN_WIDTH (LCN_WIDTH),
      .LANE_IDX  (g)
    ) u_lane (
      .base_lcn_i (base_lcn),
      .bit_i      (bitmap_byte[g]),
      .excl_lo_i  (excl_lo_q),
      .excl_hi_i  (excl_hi_q),
      .lcn_o      (lane_lcn[g]),
      .used_o     (lane_used[g])
    );
  end

  frf_merge #(
    .LCN_WIDTH (LCN_WIDTH)
  ) u_merge (
    .lcn_i            (lane_lcn),
    .used_i           (lane_used),
    .end_lcn_i        (end_lcn),
    .prev_used_i      (eff_prev_used),
    .run_start_i      (eff_run_start),
    .min_lcn_i        (min_lcn_q),
    .min_size_i       (min_size_q),
    .hit_o            (hit),
    .hit_begin_o      (hit_begin),
    .hit_end_o        (hit_end),
    .tail_ok_o        (tail_ok),
    .next_prev_used_o (next_prev_used),
    .next_run_start_o (next_run_start)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= '0;
      prev_used_q <= 1'b1;
      run_start_q <= '0;
      finished_q  <= 1'b0;
    end else if (in_beat && active) begin
      counter_q   <= end_lcn;
      prev_used_q <= next_prev_used;
      run_start_q <= next_run_start;
      finished_q  <= hit || last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      priority if (hit) begin
        found_q     <= 1'b1;
        run_begin_q <= hit_begin;
        run_end_q   <= hit_end;
      end else if (tail_ok) begin
        found_q     <= 1'b1;
        run_begin_q <= next_run_start;
        run_end_q   <= end_lcn;
      end else begin
        found_q     <= 1'b0;
        run_begin_q <= '0;
        run_end_q   <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = found_q;
  assign m_axis_tdata  = OUT_W'({run_end_q, run_begin_q});

endmodule

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import frf_pkg::*;

  localparam int unsigned LCN_W    = 40;
  localparam int unsigned S_DW     = ((8 + LCN_W + 7) / 8) * 8;
  localparam int unsigned M_DW     = ((2 * LCN_W + 7) / 8) * 8;
  localparam int unsigned NUM_REGS = 2 + 2 * NUM_EXCL;
  localparam int unsigned DIR_N    = 19;
  localparam int unsigned PHASES   = 6;
  localparam int unsigned PHASE_ITEMS = 334;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE   = 3;
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef logic [LCN_W-1:0] lcn_t;
  localparam lcn_t LCN_MAX = '1;

  typedef struct packed {
    logic found;
    lcn_t run_begin;
    lcn_t run_end;
  } run_rpt_t;

  typedef struct packed {
    logic     pinned;
    logic     emits;
    run_rpt_t rpt;
  } dir_pin_t;

  typedef struct {
    int           grp;
    logic [7:0]   bits;
    lcn_t         lcn;
    logic         start;
    logic         last;
    dir_pin_t     pin;
  } dir_row_t;

  localparam dir_pin_t PIN_PRED = '0;
  localparam dir_pin_t PIN_NONE = {1'b1, 1'b0, {($bits(run_rpt_t)){1'b0}}};

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [S_DW-1:0]  s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [M_DW-1:0]  m_axis_tdata;
  logic             m_axis_tuser;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  lcn_t             cfg_data_i = '0;

  dir_pin_t row_pin = '0;
  logic     rx_hold = 1'b0;
  int       tx_idle_pct = 0;
  int       rx_stall_pct = 0;
  int       rand_phase = -1;

  // Mirror of the register file and of the scan state.
  lcn_t        min_lcn_r = '0;
  logic [31:0] min_size_r = 32'd1;
  lcn_t        excl_lo [NUM_EXCL] = '{default: '0};
  lcn_t        excl_hi [NUM_EXCL] = '{default: '0};
  lcn_t        scan_lcn = '0;
  logic        prev_used = 1'b1;
  lcn_t        free_from = '0;
  logic        scan_done = 1'b0;

  run_rpt_t run_q [$];
  lcn_t     reg_plan [NUM_REGS];
  dir_row_t dir_rows [DIR_N];
  lcn_t     dir_regs [3][NUM_REGS];

  int items_sent = 0;
  int scans = 0;
  int reg_loads = 0;
  int results_seen = 0;
  int runs_found = 0;
  int mismatches = 0;
  int quiet = 0;

  free_cluster_run_finder #(
    .LCN_WIDTH(LCN_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic lcn_t rand_lcn();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[LCN_W-1:0];
  endfunction

  function automatic dir_pin_t pin_run(input logic found, input lcn_t b, input lcn_t e);
    dir_pin_t p;
    p.pinned = 1'b1;
    p.emits = 1'b1;
    p.rpt = {found, b, e};
    return p;
  endfunction

  function automatic logic run_ok(input lcn_t stop);
    lcn_t len;
    len = stop - free_from;
    return (free_from >= min_lcn_r) && (len >= {{(LCN_W-32){1'b0}}, min_size_r});
  endfunction

  // Steps the scan state by one byte; returns 1 when the byte yields a result.
  function automatic logic predict_run(input logic [7:0] bits, input lcn_t lcn,
                                       input logic start, input logic last,
                                       output run_rpt_t rpt);
    lcn_t c;
    logic used;
    rpt = '0;
    if (start) begin
      scan_lcn = lcn;
      prev_used = 1'b1;
      free_from = '0;
      scan_done = 1'b0;
    end
    if (scan_done) return 1'b0;
    for (int b = 0; b < 8; b++) begin
      c = scan_lcn;
      used = bits[b];
      for (int k = 0; k < NUM_EXCL; k++) begin
        if (c >= excl_lo[k] && c < excl_hi[k]) used = 1'b1;
      end
      if (!prev_used && used && run_ok(c)) begin
        rpt = {1'b1, free_from, c};
        scan_done = 1'b1;
        return 1'b1;
      end
      if (prev_used && !used) free_from = c;
      prev_used = used;
      scan_lcn = c + 1'b1;
    end
    if (last) begin
      scan_done = 1'b1;
      if (!prev_used && run_ok(scan_lcn)) rpt = {1'b1, free_from, scan_lcn};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic flag_mismatch(input string what, input lcn_t want, input lcn_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    run_rpt_t got, want, calc;
    logic emits;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[LCN_W-1:0], m_axis_tdata[2*LCN_W-1:LCN_W]};
        results_seen++;
        if (got.found) runs_found++;
        if (run_q.size() == 0) begin
          flag_mismatch("result with nothing pending, run_begin", '0, got.run_begin);
        end else begin
          want = run_q.pop_front();
          if (got.found !== want.found) begin
            flag_mismatch("found", lcn_t'(want.found), lcn_t'(got.found));
          end
          if (got.run_begin !== want.run_begin) begin
            flag_mismatch("run_begin", want.run_begin, got.run_begin);
          end
          if (got.run_end !== want.run_end) flag_mismatch("run_end", want.run_end, got.run_end);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          CFG_MIN_LCN:     min_lcn_r  = cfg_data_i;
          CFG_MIN_SIZE:    min_size_r = cfg_data_i[31:0];
          CFG_EXCL0_START: excl_lo[0] = cfg_data_i;
          CFG_EXCL0_END:   excl_hi[0] = cfg_data_i;
          CFG_EXCL1_START: excl_lo[1] = cfg_data_i;
          CFG_EXCL1_END:   excl_hi[1] = cfg_data_i;
          CFG_EXCL2_START: excl_lo[2] = cfg_data_i;
          CFG_EXCL2_END:   excl_hi[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        emits = predict_run(s_axis_tdata[7:0], s_axis_tdata[8 +: LCN_W], s_axis_tuser,
                            s_axis_tlast, calc);
        if (row_pin.pinned) begin
          if (row_pin.emits) run_q.push_back(row_pin.rpt);
        end else if (emits) begin
          run_q.push_back(calc);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // Long receiver stall while the sender keeps pushing, so the input backs up.
  initial begin
    wait (rand_phase == 4);
    repeat (50) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d results pending", quiet, run_q.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(input logic [7:0] bits, input lcn_t lcn, input logic start,
                           input logic last, input dir_pin_t pin);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lcn, bits};
    s_axis_tuser  <= start;
    s_axis_tlast  <= last;
    row_pin       <= pin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (start) scans++;
  endtask

  task automatic load_regs();
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= CFG_AW'(r);
      cfg_data_i  <= reg_plan[r];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    reg_loads++;
  endtask

  // Registers are only touched once the block has gone quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (run_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic plan_regs(input int ph, input lcn_t base);
    lcn_t lo;
    reg_plan[CFG_MIN_LCN]  = ($urandom_range(3) == 0) ? '0 : base + $urandom_range(0, 200);
    reg_plan[CFG_MIN_SIZE] = lcn_t'($urandom_range(1, 20));
    for (int k = 0; k < NUM_EXCL; k++) begin
      lo = base + $urandom_range(0, 600);
      reg_plan[int'(CFG_EXCL0_START) + 2*k] = lo;
      reg_plan[int'(CFG_EXCL0_END) + 2*k] = ($urandom_range(4) == 0) ?
          lo - $urandom_range(0, 8) : lo + $urandom_range(1, 48);
    end
    if (ph == 1) begin
      reg_plan[CFG_MIN_LCN]  = '0;
      reg_plan[CFG_MIN_SIZE] = '0;
    end else if (ph == 3) begin
      reg_plan[CFG_MIN_LCN]  = LCN_MAX;
      reg_plan[CFG_MIN_SIZE] = lcn_t'(32'hFFFF_FFFF);
    end
  endtask

  function automatic logic [7:0] pick_bits();
    logic [7:0] a, b;
    a = 8'($urandom);
    b = 8'($urandom);
    case ($urandom_range(3))
      0: return a;
      1: return a | b;
      2: return a & b;
      default: return {8{a[0]}};
    endcase
  endfunction

  initial begin
    int   cur_grp;
    int   phase_items;
    int   nbytes;
    int   kind;
    lcn_t base;
    lcn_t lcn0;
    logic broken;

    dir_rows[0]  = '{0, 8'h00, 40'h0,            1'b0, 1'b0, PIN_NONE};
    dir_rows[1]  = '{0, 8'h01, 40'h0,            1'b0, 1'b0, pin_run(1'b1, 40'h0, 40'h8)};
    dir_rows[2]  = '{0, 8'hFF, 40'h0,            1'b0, 1'b1, PIN_NONE};
    dir_rows[3]  = '{0, 8'hFF, 40'hFF_FFFF_FFF8, 1'b1, 1'b1, pin_run(1'b0, 40'h0, 40'h0)};
    dir_rows[4]  = '{0, 8'h00, 40'hFF_FFFF_FFF8, 1'b1, 1'b0, PIN_NONE};
    dir_rows[5]  = '{0, 8'hFE, 40'h0,            1'b0, 1'b1,
                     pin_run(1'b1, 40'hFF_FFFF_FFF8, 40'h1)};
    dir_rows[6]  = '{0, 8'h80, 40'h100,          1'b1, 1'b1, pin_run(1'b1, 40'h100, 40'h107)};
    dir_rows[7]  = '{0, 8'h00, 40'h200,          1'b1, 1'b1, pin_run(1'b1, 40'h200, 40'h208)};
    dir_rows[8]  = '{0, 8'hAA, 40'h0,            1'b1, 1'b1, pin_run(1'b1, 40'h0, 40'h1)};
    dir_rows[9]  = '{0, 8'h55, 40'h10,           1'b1, 1'b0, pin_run(1'b1, 40'h11, 40'h12)};
    dir_rows[10] = '{0, 8'h00, LCN_MAX,          1'b0, 1'b1, PIN_NONE};
    dir_rows[11] = '{1, 8'h00, 40'h300,          1'b1, 1'b1, PIN_PRED};
    dir_rows[12] = '{1, 8'h00, 40'h3E8,          1'b1, 1'b0, PIN_PRED};
    dir_rows[13] = '{1, 8'h00, 40'h0,            1'b0, 1'b1, PIN_PRED};
    dir_rows[14] = '{1, 8'h00, 40'h3F4,          1'b1, 1'b1, PIN_PRED};
    dir_rows[15] = '{1, 8'hF0, 40'h2F8,          1'b1, 1'b1, PIN_PRED};
    dir_rows[16] = '{2, 8'h00, 40'h0,            1'b1, 1'b1, pin_run(1'b0, 40'h0, 40'h0)};
    dir_rows[17] = '{2, 8'h00, LCN_MAX,          1'b1, 1'b1, pin_run(1'b0, 40'h0, 40'h0)};
    dir_rows[18] = '{2, 8'hFF, 40'hFF_FFFF_FFF0, 1'b1, 1'b1, pin_run(1'b0, 40'h0, 40'h0)};

    // The second set has one empty range and zero minimum length; the third one
    // holds every register at an extreme.
    dir_regs[0] = '{default: '0};
    dir_regs[1] = '{40'h301, 40'h0, 40'h305, 40'h303, 40'h302, 40'h304, 40'h3F0, 40'h3F8};
    dir_regs[2] = '{LCN_MAX, 40'hFF_FFFF_FFFF & 40'h00_FFFF_FFFF, 40'h0, LCN_MAX,
                    LCN_MAX, LCN_MAX, LCN_MAX, 40'h0};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct  = 17;
    rx_stall_pct = 63;
    cur_grp = 0;
    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].grp != cur_grp) begin
        settle();
        cur_grp = dir_rows[i].grp;
        for (int r = 0; r < NUM_REGS; r++) reg_plan[r] = dir_regs[cur_grp][r];
        load_regs();
      end
      send_item(dir_rows[i].bits, dir_rows[i].lcn, dir_rows[i].start, dir_rows[i].last,
                dir_rows[i].pin);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      tx_idle_pct  = (ph < 2) ? 17 : (ph < 4) ? 63 : 0;
      rx_stall_pct = (ph < 2) ? 63 : (ph < 4) ? 17 : 0;
      base = (ph == 5) ? LCN_MAX - $urandom_range(0, 300) : rand_lcn();
      plan_regs(ph, base);
      load_regs();
      rand_phase = ph;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 8) begin
          send_item(pick_bits(), rand_lcn(), 1'($urandom), 1'($urandom), PIN_PRED);
        end else begin
          nbytes = $urandom_range(1, 6);
          broken = (kind < 16);
          lcn0 = base + $urandom_range(0, 520);
          for (int j = 0; j < nbytes; j++) begin
            send_item(pick_bits(), (j == 0) ? lcn0 : rand_lcn(), j == 0,
                      !broken && (j == nbytes - 1), PIN_PRED);
          end
          phase_items += nbytes;
        end
      end
    end

    settle();
    $display("Sent %0d bitmap bytes in %0d scans across %0d register loads.",
             items_sent, scans, reg_loads);
    $display("Checked %0d results, %0d of them reporting a free run.",
             results_seen, runs_found);
    if (mismatches == 0 && run_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
